@@ sv/assert_macros.svh @@
// Assertion macros for RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MEXP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mexp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MEXP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mexp assertion failed");

`endif

@@ sv/mexp_pkg.sv @@
// Types and constants shared by the modular exponentiation unit.
package mexp_pkg;

  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  // Two remainder bits are retired per reduction cycle
  localparam int RED_STEPS = PROD_W / 2;
  localparam int RED_CNT_W = $clog2(RED_STEPS);

  localparam logic [DATA_W-1:0] MOD_RESET = 16'd19211;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LOAD,
    DP_MUL_SQ,
    DP_MUL_X,
    DP_REDUCE,
    DP_WB_X,
    DP_WB_ACC,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   shift_exp;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_msb;
  } dp_sts_t;

endpackage

@@ sv/mexp_in_if.sv @@
// Input channel: base and exponent with valid/ready handshake.
interface mexp_in_if;
  import mexp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

@@ sv/mexp_out_if.sv @@
// Result channel: power with valid/ready handshake.
interface mexp_out_if;
  import mexp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

@@ sv/mexp_ctrl.sv @@
// Sequencer for square-and-multiply: issues datapath operations per exponent bit.
module mexp_ctrl import mexp_pkg::*; #(
  parameter int EXP_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam int BITS_W = $clog2(EXP_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RED,
    S_WB,
    S_DONE
  } state_t;

  // What the multiplication in flight is for
  typedef enum logic [1:0] {
    PH_BASE,
    PH_SQ,
    PH_MUL
  } phase_t;

  state_t                 state_r, state_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [BITS_W-1:0]      bits_r, bits_nxt;
  logic [RED_CNT_W-1:0]   red_r, red_nxt;
  logic                   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    bits_nxt      = bits_r;
    red_nxt       = red_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = DP_IDLE;
    cmd.shift_exp = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          bits_nxt  = BITS_W'(EXP_BITS);
          phase_nxt = PH_BASE;
          red_nxt   = '0;
          state_nxt = S_RED;
        end
      end
      S_MUL: begin
        cmd.op    = (phase_r == PH_SQ) ? DP_MUL_SQ : DP_MUL_X;
        red_nxt   = '0;
        state_nxt = S_RED;
      end
      S_RED: begin
        cmd.op  = DP_REDUCE;
        red_nxt = red_r + RED_CNT_W'(1);
        if (red_r == RED_CNT_W'(RED_STEPS - 1)) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.op = (phase_r == PH_BASE) ? DP_WB_X : DP_WB_ACC;
        if (phase_r == PH_BASE) begin
          phase_nxt = PH_SQ;
          state_nxt = S_MUL;
        end else if (phase_r == PH_SQ && sts.exp_msb) begin
          phase_nxt = PH_MUL;
          state_nxt = S_MUL;
        end else begin
          // Bit finished: move to the next exponent bit
          cmd.shift_exp = 1'b1;
          bits_nxt      = bits_r - BITS_W'(1);
          phase_nxt     = PH_SQ;
          state_nxt     = (bits_r == BITS_W'(1)) ? S_DONE : S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_BASE;
      bits_r      <= '0;
      red_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      bits_r      <= bits_nxt;
      red_r       <= red_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/mexp_dp.sv @@
// Datapath: modulus register, 16x16 multiplier and two-bit-per-cycle reduction.
module mexp_dp import mexp_pkg::*; #(
  parameter int EXP_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [DATA_W-1:0] base,
  input  logic [DATA_W-1:0] exponent,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata,
  output logic [DATA_W-1:0] power,
  output dp_sts_t           sts
);

  logic [DATA_W-1:0]          mod_r;
  logic [DATA_W-1:0]          acc_r;
  logic [DATA_W-1:0]          x_r;
  logic [DATA_W-1:0]          rem_r, rem_nxt;
  logic [PROD_W-1:0]          prod_r;
  logic [EXP_BITS-1:0]        exp_r;
  logic [DATA_W-1:0]          power_r;
  logic [EXP_BITS+DATA_W-1:0] exp_ext;
  logic [DATA_W-1:0]          mul_b;
  logic [PROD_W-1:0]          mul_p;
  logic [DATA_W:0]            t1, t2;

  // Exponent bits above EXP_BITS are dropped, missing ones read as zero
  assign exp_ext = {{EXP_BITS{1'b0}}, exponent};

  assign mul_b = (cmd.op == DP_MUL_SQ) ? acc_r : x_r;
  assign mul_p = {{DATA_W{1'b0}}, acc_r} * {{DATA_W{1'b0}}, mul_b};

  // Two restoring remainder steps, product bits fed in MSB first
  always_comb begin
    t1 = {rem_r, prod_r[PROD_W-1]};
    if (t1 >= {1'b0, mod_r}) begin
      t1 = t1 - {1'b0, mod_r};
    end
    t2 = {t1[DATA_W-1:0], prod_r[PROD_W-2]};
    if (t2 >= {1'b0, mod_r}) begin
      t2 = t2 - {1'b0, mod_r};
    end
    rem_nxt = t2[DATA_W-1:0];
  end

  // Modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_RESET;
    end else if (cfg_we) begin
      mod_r <= cfg_wdata;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op) inside
      DP_LOAD: begin
        prod_r <= {{DATA_W{1'b0}}, base};
        rem_r  <= '0;
        exp_r  <= exp_ext[EXP_BITS-1:0];
        acc_r  <= {{(DATA_W-1){1'b0}}, (mod_r != DATA_W'(1))};
      end
      DP_MUL_SQ, DP_MUL_X: begin
        prod_r <= mul_p;
        rem_r  <= '0;
      end
      DP_REDUCE: begin
        prod_r <= {prod_r[PROD_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
      end
      DP_WB_X: begin
        x_r <= rem_r;
      end
      DP_WB_ACC: begin
        acc_r <= rem_r;
      end
      DP_OUT: begin
        power_r <= (mod_r == '0) ? '0 : acc_r;
      end
      default: begin
      end
    endcase
    if (cmd.shift_exp) begin
      exp_r <= exp_r << 1;
    end
  end

  assign power       = power_r;
  assign sts.exp_msb = exp_r[EXP_BITS-1];

endmodule

@@ sv/modular_exponentiation_unit.sv @@
// Top level of the modular exponentiation unit: controller plus datapath.
//
//   channel  | direction | payload              | handshake
//   in_ch    | in        | base, exponent       | valid/ready
//   out_ch   | out       | power                | valid/ready
//   cfg      | in        | cfg_wdata (modulus)  | cfg_we, no stall
//
// Each modular multiply is a multiply step, then reduction steps that
// retire two remainder bits each, then a write-back.
// One item is in work at a time; a finished result waits in the output
// register and the next item is taken meanwhile.
// Synchronous active-low reset; modulus resets to 19211.
`include "assert_macros.svh"

module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int EXP_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  mexp_in_if.sink           in_ch,
  mexp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  mexp_ctrl #(
    .EXP_BITS (EXP_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  mexp_dp #(
    .EXP_BITS (EXP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .base      (in_ch.base),
    .exponent  (in_ch.exponent),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .power     (out_ch.power),
    .sts       (dp_sts)
  );

  // Accepted item loads the datapath and starts the base reduction
  `MEXP_ASSERT_IMP(a_accept_loads, in_ch.valid && in_ch.ready, dp_cmd.op == DP_LOAD)
  `MEXP_ASSERT_NXT(a_load_reduces, dp_cmd.op == DP_LOAD, dp_cmd.op == DP_REDUCE)
  // Result register is only overwritten when its item is gone or leaving
  `MEXP_ASSERT_IMP(a_out_no_overwrite, dp_cmd.op == DP_OUT, !out_ch.valid || out_ch.ready)

endmodule
